// File: rtl/aorf_pkg.sv
// Types and constants shared by the relocation field patcher.
package aorf_pkg;

  // Relocation types
  localparam logic [4:0] OpReloc8       = 5'd0;
  localparam logic [4:0] OpReloc16      = 5'd1;
  localparam logic [4:0] OpReloc32      = 5'd2;
  localparam logic [4:0] OpDisp8        = 5'd3;
  localparam logic [4:0] OpDisp16       = 5'd4;
  localparam logic [4:0] OpDisp32       = 5'd5;
  localparam logic [4:0] OpWdisp30      = 5'd6;
  localparam logic [4:0] OpWdisp22      = 5'd7;
  localparam logic [4:0] OpHi22         = 5'd8;
  localparam logic [4:0] OpReloc22      = 5'd9;
  localparam logic [4:0] OpReloc13      = 5'd10;
  localparam logic [4:0] OpLo10         = 5'd11;
  localparam logic [4:0] OpBase10       = 5'd14;
  localparam logic [4:0] OpBase13       = 5'd15;
  localparam logic [4:0] OpBase22       = 5'd16;
  localparam logic [4:0] OpGlobDat      = 5'd21;
  localparam logic [4:0] OpJmpSlot      = 5'd22;
  localparam logic [4:0] OpRelative     = 5'd23;

  // Field masks and the HI22 shift
  localparam logic [31:0] Mask8  = 32'h0000_00FF;
  localparam logic [31:0] Mask10 = 32'h0000_03FF;
  localparam logic [31:0] Mask13 = 32'h0000_1FFF;
  localparam logic [31:0] Mask16 = 32'h0000_FFFF;
  localparam logic [31:0] Mask22 = 32'h003F_FFFF;
  localparam logic [31:0] Mask30 = 32'h3FFF_FFFF;
  localparam int unsigned HiShift = 32 - 22;

  // Register addresses
  localparam logic [1:0] AddrObjectBase = 2'd0;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StOverflow = 2'd1,
    StUnsup    = 2'd2,
    StSkip     = 2'd3
  } status_e;

  typedef struct packed {
    logic [4:0]         op;
    logic               is_external;
    logic [31:0]        symbol_value;
    logic signed [31:0] addend;
    logic [31:0]        definer_base;
    logic               add_definer_base;
    logic [31:0]        target_word;
    logic [31:0]        next_word;
  } reloc_in_t;

  typedef struct packed {
    logic [31:0] patched_word;
    logic [31:0] patched_next_word;
    status_e     status;
  } reloc_out_t;

endpackage

// File: rtl/aout_reloc_field_patch.sv
// Relocation field patcher: input register, patch logic, result register.
//
// Usage:
//   One relocation entry enters per word on the in channel (valid/ready) and
//   one result word leaves on the out channel (valid/ready): the patched
//   target word, the patched following word and a status (ok, overflow with
//   the patch still written, unsupported type, skipped jump slot).
//   The object's load address is written over the APB-style port at byte
//   address 0; pready is always high and reads return the register.
//   A word accepted into the input register is patched there and moves into
//   the result register, from which it is offered on the out channel. One
//   entry is accepted every cycle while the receiver takes results; the patch
//   logic between the input and result registers is combinational.
//   The input register keeps accepting while a finished result waits: a
//   new word is taken whenever the input register is empty or will move on.
//   When the receiver stalls with both registers full, in_ready_o drops and
//   both words are held.
//   Reset clears both valid bits and sets the object base to 0.
module aout_reloc_field_patch
  import aorf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  reloc_in_t   in_data_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output reloc_out_t  out_data_o,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [31:0] obase_q;
  logic        s1_valid_q, s2_valid_q;
  reloc_in_t   s1_q;
  reloc_out_t  s2_q, s2_d;
  logic        adv2, adv1;

  // Configuration register write and read
  assign pready = 1'b1;
  assign prdata = (paddr == AddrObjectBase) ? obase_q : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      obase_q <= 32'd0;
    end else if (psel && penable && pwrite && paddr == AddrObjectBase) begin
      obase_q <= pwdata;
    end
  end

  // Handshake: result register frees when taken, input register when it moves on
  assign adv2       = !s2_valid_q || out_ready_i;
  assign adv1       = s1_valid_q && adv2;
  assign in_ready_o = !s1_valid_q || adv2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (adv2) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_q <= in_data_i;
    end
    if (adv1) begin
      s2_q <= s2_d;
    end
  end

  // Patch logic
  logic        pc_rel;
  logic [31:0] val, fld, sum, w, nw, db_term, ob_term;
  logic [9:0]  lo10;
  status_e     st;

  always_comb begin
    pc_rel  = (s1_q.op >= OpDisp8) && (s1_q.op <= OpWdisp22);
    db_term = s1_q.add_definer_base ? s1_q.definer_base : 32'd0;
    ob_term = pc_rel ? obase_q : 32'd0;
    // form the relocation value
    if (s1_q.is_external) begin
      val = s1_q.symbol_value + $unsigned(s1_q.addend) + db_term - ob_term;
    end else begin
      val = obase_q;
    end
    // pick the field contents to add in
    case (s1_q.op)
      OpReloc8, OpDisp8:              fld = s1_q.target_word & Mask8;
      OpLo10, OpBase10:               fld = s1_q.target_word & Mask10;
      OpReloc13, OpBase13:            fld = s1_q.target_word & Mask13;
      OpReloc16, OpDisp16:            fld = s1_q.target_word & Mask16;
      OpReloc22, OpBase22, OpWdisp22: fld = s1_q.target_word & Mask22;
      OpHi22, OpRelative:             fld = s1_q.target_word << HiShift;
      OpWdisp30:                      fld = s1_q.target_word & Mask30;
      default:                        fld = s1_q.target_word;
    endcase
    sum  = val + fld;
    lo10 = sum[9:0] + s1_q.next_word[9:0];
    w    = s1_q.target_word;
    nw   = s1_q.next_word;
    st   = StOk;
    // patch the field and check range
    case (s1_q.op)
      OpRelative: begin
        w  = {s1_q.target_word[31:22], sum[31:10]};
        nw = {s1_q.next_word[31:10], lo10};
      end
      OpReloc8, OpDisp8: begin
        w = {s1_q.target_word[31:8], sum[7:0]};
        if (!(&sum[31:8] || ~|sum[31:8])) st = StOverflow;
      end
      OpLo10, OpBase10: begin
        w = {s1_q.target_word[31:10], sum[9:0]};
      end
      OpReloc13, OpBase13: begin
        w = {s1_q.target_word[31:13], sum[12:0]};
      end
      OpReloc16, OpDisp16: begin
        w = {s1_q.target_word[31:16], sum[15:0]};
        if (!(&sum[31:16] || ~|sum[31:16])) st = StOverflow;
      end
      OpReloc22, OpBase22: begin
        w = {s1_q.target_word[31:22], sum[21:0]};
        if (!(&sum[31:22] || ~|sum[31:22])) st = StOverflow;
      end
      OpHi22: begin
        w = {s1_q.target_word[31:22], sum[31:10]};
      end
      OpWdisp22: begin
        w = {s1_q.target_word[31:22], sum[23:2]};
        if (!(&sum[31:24] || ~|sum[31:24])) st = StOverflow;
      end
      OpWdisp30: begin
        w = {s1_q.target_word[31:30], sum[31:2]};
      end
      OpReloc32, OpDisp32, OpGlobDat: begin
        w = sum;
      end
      default: begin
        st = StUnsup;
      end
    endcase
    // drop the patch for an external jump slot
    if (s1_q.is_external && s1_q.op == OpJmpSlot) begin
      w  = s1_q.target_word;
      nw = s1_q.next_word;
      st = StSkip;
    end
    s2_d.patched_word      = w;
    s2_d.patched_next_word = nw;
    s2_d.status            = st;
  end

  assign out_valid_o = s2_valid_q;
  assign out_data_o  = s2_q;

`ifndef ASSERT_OFF
  // a full pipe facing a stalled receiver takes no new word
  a_hold_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s2_valid_q && !out_ready_i) |-> !in_ready_o)
    else $error("input accepted while both registers full and stalled");
  // an accepted word lands in the input register
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> s1_valid_q)
    else $error("accepted word lost from input register");
  // a word that moves on is offered at the output next cycle
  a_advance_offers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv1 |=> out_valid_o)
    else $error("advanced word not offered at output");
`endif

endmodule

// File: test/aout_reloc_field_patch_tb.sv
// Self-checking testbench for the relocation field patcher: random and directed words.
module aout_reloc_field_patch_tb
  import aorf_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QuietLimit = 2000;
  localparam int PhaseWords = 300;
  localparam int HoldCycles = 64;
  localparam int FieldBits[4] = '{8, 16, 22, 24};

  // Expected patches, worked out from each accepted relocation word
  class patch_checker;
    logic [31:0] base;
    int unsigned errors;
    reloc_out_t  expected_q[$];

    function new();
      base = '0;
      errors = 0;
    endfunction

    // Signed (n+1)-bit range check: -2^n <= v < 2^n
    function bit fits_field(logic [31:0] v, int n);
      longint s;
      s = longint'($signed(v));
      return s >= -(longint'(1) << n) && s < (longint'(1) << n);
    endfunction

    function reloc_out_t patch_fields(reloc_in_t e);
      reloc_out_t r;
      logic [31:0] v;
      logic [31:0] w;
      logic [31:0] nw;
      status_e     st;
      w  = e.target_word;
      nw = e.next_word;
      st = StOk;
      if (!e.is_external) begin
        v = base;
      end else if (e.op == OpJmpSlot) begin
        r.patched_word = w;
        r.patched_next_word = nw;
        r.status = StSkip;
        return r;
      end else begin
        v = e.symbol_value + e.addend;
        if (e.add_definer_base) v += e.definer_base;
        // PC-relative types are taken relative to the object's own base
        if (e.op >= OpDisp8 && e.op <= OpWdisp22) v -= base;
      end
      case (e.op)
        OpRelative: begin
          v += w << HiShift;
          w = (w & ~Mask22) | ((v >> HiShift) & Mask22);
          v += nw & Mask10;
          nw = (nw & ~Mask10) | (v & Mask10);
        end
        OpReloc8, OpDisp8: begin
          v += w & Mask8;
          if (!fits_field(v, 8)) st = StOverflow;
          w = (w & ~Mask8) | (v & Mask8);
        end
        OpLo10, OpBase10: begin
          v += w & Mask10;
          w = (w & ~Mask10) | (v & Mask10);
        end
        OpReloc13, OpBase13: begin
          v += w & Mask13;
          w = (w & ~Mask13) | (v & Mask13);
        end
        OpReloc16, OpDisp16: begin
          v += w & Mask16;
          if (!fits_field(v, 16)) st = StOverflow;
          w = (w & ~Mask16) | (v & Mask16);
        end
        OpReloc22, OpBase22: begin
          v += w & Mask22;
          if (!fits_field(v, 22)) st = StOverflow;
          w = (w & ~Mask22) | (v & Mask22);
        end
        OpHi22: begin
          v += (w & Mask22) << HiShift;
          w = (w & ~Mask22) | ((v >> HiShift) & Mask22);
        end
        OpWdisp22: begin
          v += w & Mask22;
          v = $unsigned($signed(v) >>> 2);
          if (!fits_field(v, 22)) st = StOverflow;
          w = (w & ~Mask22) | (v & Mask22);
        end
        OpWdisp30: begin
          v += w & Mask30;
          v = $unsigned($signed(v) >>> 2);
          w = (w & ~Mask30) | (v & Mask30);
        end
        OpReloc32, OpDisp32, OpGlobDat: begin
          w = v + w;
        end
        default: begin
          st = StUnsup;
        end
      endcase
      r.patched_word = w;
      r.patched_next_word = nw;
      r.status = st;
      return r;
    endfunction

    function void note_entry(reloc_in_t e);
      expected_q.push_back(patch_fields(e));
    endfunction

    function void check_patch(reloc_out_t got);
      reloc_out_t exp_w;
      if (expected_q.size() == 0) begin
        $error("result word with nothing expected: %h", got);
        errors++;
        return;
      end
      exp_w = expected_q.pop_front();
      if (got.patched_word !== exp_w.patched_word) begin
        $error("patched_word: expected %h, got %h", exp_w.patched_word, got.patched_word);
        errors++;
      end
      if (got.patched_next_word !== exp_w.patched_next_word) begin
        $error("patched_next_word: expected %h, got %h",
               exp_w.patched_next_word, got.patched_next_word);
        errors++;
      end
      if (got.status !== exp_w.status) begin
        $error("status: expected %0d, got %0d", exp_w.status, got.status);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  reloc_in_t   in_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  reloc_out_t  out_data_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  patch_checker sb;
  bit           idling_on = 1'b1;
  bit           hold_req = 1'b0;
  int           quiet_cycles = 0;

  aout_reloc_field_patch dut (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Offer one word, idling first at random, and hold it until taken
  task automatic send_entry(reloc_in_t e);
    if (idling_on && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= e;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_entry(e);
  endtask

  // Drop valid and wait for every outstanding patch to come back
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Setup then access cycle; the register takes the value when pready is high
  task automatic write_object_base(logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrObjectBase;
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.base = val;
  endtask

  task automatic run_directed();
    reloc_in_t e;
    // every relocation type, external, over a patterned target word
    for (int k = 0; k <= OpRelative; k++) begin
      e.op = 5'(k);
      e.is_external = 1'b1;
      e.symbol_value = 32'h0000_0F00 + 32'(k);
      e.addend = -32'sd5;
      e.definer_base = 32'h0001_0000;
      e.add_definer_base = k[0];
      e.target_word = 32'hA5A5_A5A5;
      e.next_word = 32'h5A5A_5A5A;
      send_entry(e);
    end
    // all-zero internal entry, all-ones unsupported entry
    e = '0;
    send_entry(e);
    e = '1;
    send_entry(e);
    // jump slot: unsupported when internal, skipped when external
    e = '0;
    e.op = OpJmpSlot;
    e.target_word = '1;
    send_entry(e);
    e.is_external = 1'b1;
    send_entry(e);
    // byte field at the edges of its range
    e = '0;
    e.op = OpReloc8;
    e.is_external = 1'b1;
    e.symbol_value = 32'd255;
    send_entry(e);
    e.symbol_value = 32'd256;
    send_entry(e);
    e.symbol_value = '0;
    e.addend = -32'sd257;
    send_entry(e);
  endtask

  // Mostly well-formed entries aimed at field boundaries, the rest plain noise
  function automatic reloc_in_t make_entry();
    reloc_in_t   e;
    logic [31:0] t;
    int          n;
    e.op = 5'($urandom);
    e.is_external = 1'($urandom);
    e.symbol_value = $urandom;
    e.addend = $urandom;
    e.definer_base = $urandom;
    e.add_definer_base = 1'($urandom);
    e.target_word = $urandom;
    e.next_word = $urandom;
    if ($urandom_range(0, 9) < 3) return e;
    e.op = 5'($urandom_range(0, OpRelative));
    e.is_external = ($urandom_range(0, 4) != 0);
    n = FieldBits[$urandom_range(0, 3)];
    t = 32'($urandom_range(0, 4)) - 32'd2;
    case ($urandom_range(0, 2))
      0: t += 32'd1 << n;
      1: t -= 32'd1 << n;
      default: t += 32'($urandom_range(0, 511)) - 32'd256;
    endcase
    // solve the symbol value back from the wanted relocation value
    e.addend = 32'($urandom_range(0, 2000)) - 32'd1000;
    e.symbol_value = t - e.addend;
    if (e.add_definer_base) e.symbol_value -= e.definer_base;
    if (e.op >= OpDisp8 && e.op <= OpWdisp22) e.symbol_value += sb.base;
    if ($urandom_range(0, 1) != 0) e.target_word &= ~Mask22;
    return e;
  endfunction

  // Main sequence: reset, directed words, then random phases per object base
  initial begin
    logic [31:0] bases[6];
    sb = new();
    bases = '{32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
              $urandom, $urandom};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    for (int p = 0; p < 6; p++) begin
      drain();
      write_object_base(bases[p]);
      idling_on = (p < 5);
      if (p == 1) hold_req = 1'b1;
      repeat (PhaseWords) send_entry(make_entry());
    end
    drain();
    repeat (4) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Receiver: random stall bursts, and one long hold to back the block up
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Check each result word taken; end the run if nothing moves for too long
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_patch(out_data_o);
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QuietLimit) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
